>>> rtl/gap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_pkg
// shared types and constants of the articulation point finder
// ----------------------------------------------------------------------------
package gap_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = VIDX_W + 1;
    localparam int LOW_W        = VIDX_W;

    localparam logic [CNT_W-1:0] NO_PARENT = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_A,
        ST_LOAD_B,
        ST_START,
        ST_ROOT,
        ST_ROW,
        ST_SCAN,
        ST_BACK,
        ST_POP_STACK,
        ST_POP_REC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] disc;
        logic [CNT_W-1:0] parent;
    } visit_rec_t;

    typedef struct packed {
        logic [LOW_W-1:0] low;
        logic [CNT_W-1:0] scan;
    } resume_rec_t;

endpackage

>>> rtl/gap_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module gap_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/gap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_core
// edge loader, depth-first search sequencer and result emitter
// ----------------------------------------------------------------------------
module gap_core
    import gap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  count,
    input  logic              edge_valid,
    output logic              edge_ready,
    input  logic [VIDX_W-1:0] edge_a,
    input  logic [VIDX_W-1:0] edge_b,
    input  logic              last_edge,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [VIDX_W-1:0] vertex_index,
    output logic              is_cut_vertex,
    output logic              last_vertex
);

    localparam int V = MAX_VERTICES;

    state_t state_reg, state_next;

    logic [VIDX_W-1:0] a_reg, a_next, b_reg, b_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [V-1:0]      rowvld_reg, rowvld_next;
    logic [V-1:0]      vis_reg, vis_next;
    logic [V-1:0]      cut_reg, cut_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  root_reg, root_next;
    logic [VIDX_W-1:0] u_reg, u_next;
    logic [VIDX_W-1:0] v_reg, v_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [V-1:0]      row_reg, row_next;
    logic [LOW_W-1:0]  lowu_reg, lowu_next;
    logic [CNT_W-1:0]  paru_reg, paru_next;
    logic [LOW_W-1:0]  lowc_reg, lowc_next;
    logic [CNT_W-1:0]  sp_reg, sp_next;
    logic [CNT_W-1:0]  rcc_reg, rcc_next;
    logic [CNT_W-1:0]  emit_reg, emit_next;

    logic              adj_we;
    logic [VIDX_W-1:0] adj_waddr, adj_raddr;
    logic [V-1:0]      adj_wdata, adj_rdata, adj_row;

    logic              va_we;
    logic [VIDX_W-1:0] va_waddr, va_raddr;
    visit_rec_t        va_wdata, va_rdata;

    logic              rs_we;
    logic [VIDX_W-1:0] rs_waddr, rs_raddr;
    resume_rec_t       rs_wdata, rs_rdata;

    logic              st_we;
    logic [VIDX_W-1:0] st_waddr, st_raddr;
    logic [VIDX_W-1:0] st_wdata, st_rdata;

    logic              edge_ok;
    logic [CNT_W-1:0]  sp_dec;
    logic [CNT_W-1:0]  sp_dec2;

    gap_ram #(.WIDTH(V), .ADDR_W(VIDX_W)) u_adj (
        .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
        .raddr(adj_raddr), .rdata(adj_rdata)
    );

    gap_ram #(.WIDTH($bits(visit_rec_t)), .ADDR_W(VIDX_W)) u_visit (
        .clk(clk), .we(va_we), .waddr(va_waddr), .wdata(va_wdata),
        .raddr(va_raddr), .rdata(va_rdata)
    );

    gap_ram #(.WIDTH($bits(resume_rec_t)), .ADDR_W(VIDX_W)) u_resume (
        .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
        .raddr(rs_raddr), .rdata(rs_rdata)
    );

    gap_ram #(.WIDTH(VIDX_W), .ADDR_W(VIDX_W)) u_stack (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rowvld_reg <= '0;
            vis_reg    <= '0;
            cut_reg    <= '0;
            cnt_reg    <= '0;
            rcc_reg    <= '0;
            sp_reg     <= '0;
            root_reg   <= '0;
            emit_reg   <= '0;
            n_reg      <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rowvld_reg <= rowvld_next;
            vis_reg    <= vis_next;
            cut_reg    <= cut_next;
            cnt_reg    <= cnt_next;
            rcc_reg    <= rcc_next;
            sp_reg     <= sp_next;
            root_reg   <= root_next;
            emit_reg   <= emit_next;
            n_reg      <= n_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        scan_reg  <= scan_next;
        row_reg   <= row_next;
        lowu_reg  <= lowu_next;
        paru_reg  <= paru_next;
        lowc_reg  <= lowc_next;
    end

    assign edge_ok = ({1'b0, edge_a} < count) && ({1'b0, edge_b} < count)
                     && (edge_a != edge_b);
    assign sp_dec  = sp_reg - CNT_W'(1);
    assign sp_dec2 = sp_reg - CNT_W'(2);

    always_comb
    begin
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        last_next   = last_reg;
        n_next      = n_reg;
        rowvld_next = rowvld_reg;
        vis_next    = vis_reg;
        cut_next    = cut_reg;
        cnt_next    = cnt_reg;
        root_next   = root_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        scan_next   = scan_reg;
        row_next    = row_reg;
        lowu_next   = lowu_reg;
        paru_next   = paru_reg;
        lowc_next   = lowc_reg;
        sp_next     = sp_reg;
        rcc_next    = rcc_reg;
        emit_next   = emit_reg;

        adj_we    = 1'b0;
        adj_waddr = a_reg;
        adj_wdata = '0;
        adj_raddr = u_reg;
        adj_row   = rowvld_reg[a_reg] ? adj_rdata : '0;
        va_we     = 1'b0;
        va_waddr  = u_reg;
        va_wdata  = '0;
        va_raddr  = v_reg;
        rs_we     = 1'b0;
        rs_waddr  = u_reg;
        rs_wdata  = '0;
        rs_raddr  = u_reg;
        st_we     = 1'b0;
        st_waddr  = sp_reg[VIDX_W-1:0];
        st_wdata  = u_reg;
        st_raddr  = sp_dec2[VIDX_W-1:0];

        edge_ready    = 1'b0;
        result_valid  = 1'b0;
        vertex_index  = emit_reg[VIDX_W-1:0];
        is_cut_vertex = cut_reg[emit_reg[VIDX_W-1:0]];
        last_vertex   = (emit_reg + CNT_W'(1)) == n_reg;

        case (state_reg)
            ST_IDLE:
            begin
                edge_ready = 1'b1;
                if (edge_valid)
                begin
                    a_next    = edge_a;
                    b_next    = edge_b;
                    last_next = last_edge;
                    n_next    = count;
                    adj_raddr = edge_a;
                    if (edge_ok)
                    begin
                        state_next = ST_LOAD_A;
                    end
                    else if (last_edge)
                    begin
                        state_next = ST_START;
                    end
                end
            end

            ST_LOAD_A:
            begin
                adj_we             = 1'b1;
                adj_waddr          = a_reg;
                adj_wdata          = adj_row | (V'(1) << b_reg);
                rowvld_next[a_reg] = 1'b1;
                adj_raddr          = b_reg;
                state_next         = ST_LOAD_B;
            end

            ST_LOAD_B:
            begin
                adj_row            = rowvld_reg[b_reg] ? adj_rdata : '0;
                adj_we             = 1'b1;
                adj_waddr          = b_reg;
                adj_wdata          = adj_row | (V'(1) << a_reg);
                rowvld_next[b_reg] = 1'b1;
                state_next         = last_reg ? ST_START : ST_IDLE;
            end

            ST_START:
            begin
                vis_next   = '0;
                cut_next   = '0;
                cnt_next   = '0;
                root_next  = '0;
                state_next = ST_ROOT;
            end

            ST_ROOT:
            begin
                if (root_reg >= n_reg)
                begin
                    emit_next = '0;
                    if (n_reg == '0)
                    begin
                        rowvld_next = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else if (vis_reg[root_reg[VIDX_W-1:0]])
                begin
                    root_next = root_reg + CNT_W'(1);
                end
                else
                begin
                    // open a new tree at this root
                    va_we           = 1'b1;
                    va_waddr        = root_reg[VIDX_W-1:0];
                    va_wdata.disc   = cnt_reg;
                    va_wdata.parent = NO_PARENT;
                    st_we           = 1'b1;
                    st_waddr        = '0;
                    st_wdata        = root_reg[VIDX_W-1:0];
                    vis_next[root_reg[VIDX_W-1:0]] = 1'b1;
                    u_next     = root_reg[VIDX_W-1:0];
                    lowu_next  = cnt_reg[LOW_W-1:0];
                    paru_next  = NO_PARENT;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    scan_next  = '0;
                    sp_next    = CNT_W'(1);
                    rcc_next   = '0;
                    adj_raddr  = root_reg[VIDX_W-1:0];
                    state_next = ST_ROW;
                end
            end

            ST_ROW:
            begin
                row_next   = rowvld_reg[u_reg] ? adj_rdata : '0;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (scan_reg >= n_reg)
                begin
                    // all neighbors done, return to the parent or, at the root, move to the next root
                    sp_next   = sp_dec;
                    lowc_next = lowu_reg;
                    if (sp_dec == '0)
                    begin
                        if (rcc_reg > CNT_W'(1))
                        begin
                            cut_next[root_reg[VIDX_W-1:0]] = 1'b1;
                        end
                        root_next  = root_reg + CNT_W'(1);
                        state_next = ST_ROOT;
                    end
                    else
                    begin
                        st_raddr   = sp_dec2[VIDX_W-1:0];
                        state_next = ST_POP_STACK;
                    end
                end
                else if (row_reg[scan_reg[VIDX_W-1:0]])
                begin
                    v_next    = scan_reg[VIDX_W-1:0];
                    scan_next = scan_reg + CNT_W'(1);
                    if (!vis_reg[scan_reg[VIDX_W-1:0]])
                    begin
                        // tree edge: descend into the neighbor
                        va_we           = 1'b1;
                        va_waddr        = scan_reg[VIDX_W-1:0];
                        va_wdata.disc   = cnt_reg;
                        va_wdata.parent = {1'b0, u_reg};
                        rs_we           = 1'b1;
                        rs_waddr        = u_reg;
                        rs_wdata.low    = lowu_reg;
                        rs_wdata.scan   = scan_reg + CNT_W'(1);
                        st_we           = 1'b1;
                        st_waddr        = sp_reg[VIDX_W-1:0];
                        st_wdata        = scan_reg[VIDX_W-1:0];
                        sp_next         = sp_reg + CNT_W'(1);
                        if ({1'b0, u_reg} == root_reg)
                        begin
                            rcc_next = rcc_reg + CNT_W'(1);
                        end
                        vis_next[scan_reg[VIDX_W-1:0]] = 1'b1;
                        u_next     = scan_reg[VIDX_W-1:0];
                        lowu_next  = cnt_reg[LOW_W-1:0];
                        paru_next  = {1'b0, u_reg};
                        cnt_next   = cnt_reg + CNT_W'(1);
                        scan_next  = '0;
                        adj_raddr  = scan_reg[VIDX_W-1:0];
                        state_next = ST_ROW;
                    end
                    else
                    begin
                        va_raddr   = scan_reg[VIDX_W-1:0];
                        state_next = ST_BACK;
                    end
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            ST_BACK:
            begin
                if (({1'b0, v_reg} != paru_reg) && (va_rdata.disc < {1'b0, lowu_reg}))
                begin
                    lowu_next = va_rdata.disc[LOW_W-1:0];
                end
                state_next = ST_SCAN;
            end

            ST_POP_STACK:
            begin
                u_next     = st_rdata;
                va_raddr   = st_rdata;
                rs_raddr   = st_rdata;
                adj_raddr  = st_rdata;
                state_next = ST_POP_REC;
            end

            ST_POP_REC:
            begin
                paru_next  = va_rdata.parent;
                scan_next  = rs_rdata.scan;
                lowu_next  = (lowc_reg < rs_rdata.low) ? lowc_reg : rs_rdata.low;
                row_next   = rowvld_reg[u_reg] ? adj_rdata : '0;
                if ((va_rdata.parent != NO_PARENT) && ({1'b0, lowc_reg} >= va_rdata.disc))
                begin
                    cut_next[u_reg] = 1'b1;
                end
                state_next = ST_SCAN;
            end

            ST_EMIT:
            begin
                result_valid = 1'b1;
                if (result_ready)
                begin
                    if (last_vertex)
                    begin
                        rowvld_next = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        emit_next = emit_reg + CNT_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/graph_articulation_point_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_articulation_point_finder
// loads an undirected graph edge by edge and reports its cut vertices
// ----------------------------------------------------------------------------
// An edge transaction is dropped when an endpoint is out of range or the edge is
// a self loop; a stored edge passes ST_LOAD_A and ST_LOAD_B, since each endpoint
// row of the adjacency ram is read, or-ed and written back. After the edge
// marked last, the depth-first search scans neighbor bits one per cycle with a
// single scan and compare unit; each neighbor that is already visited also
// passes through ST_BACK. Then one result transaction per vertex follows,
// one per cycle while result_ready is high.
// No clearing pass is needed: row valid flags empty the graph at once.
// edge_ready is low from the last edge until the final result is taken.
// ----------------------------------------------------------------------------
module graph_articulation_point_finder
    import gap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              edge_valid,
    output logic              edge_ready,
    input  logic [VIDX_W-1:0] edge_a,
    input  logic [VIDX_W-1:0] edge_b,
    input  logic              last_edge,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [VIDX_W-1:0] vertex_index,
    output logic              is_cut_vertex,
    output logic              last_vertex
);

    localparam logic [1:0]       ADDR_VERTEX_COUNT = 2'd0;
    localparam logic [CNT_W-1:0] COUNT_LIMIT       = CNT_W'(MAX_VERTICES);

    logic [6:0]       vcount_reg;
    logic [CNT_W-1:0] count_eff;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= 7'd64;
        end
        else if (psel && penable && pwrite)
        begin
            vcount_reg <= pwdata[6:0];
        end
    end

    assign prdata    = (paddr == ADDR_VERTEX_COUNT) ? {25'd0, vcount_reg} : '0;
    assign count_eff = ({1'b0, vcount_reg} > 8'(COUNT_LIMIT)) ? COUNT_LIMIT
                                                              : CNT_W'(vcount_reg);

    gap_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .count         (count_eff),
        .edge_valid    (edge_valid),
        .edge_ready    (edge_ready),
        .edge_a        (edge_a),
        .edge_b        (edge_b),
        .last_edge     (last_edge),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .vertex_index  (vertex_index),
        .is_cut_vertex (is_cut_vertex),
        .last_vertex   (last_vertex)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(edge_ready && result_valid))
        else $error("edge and result channels active together");

    a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && last_vertex |=> !result_valid)
        else $error("result after final vertex");

    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !last_vertex |=>
            result_valid && (vertex_index == $past(vertex_index) + VIDX_W'(1)))
        else $error("vertex results out of order");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the articulation point finder
// ----------------------------------------------------------------------------
// Edges are streamed into the block under random idling on both sides, with
// the vertex count changed between graphs over its full range. A local
// depth-first search predicts the cut flag of every vertex when a graph is
// closed, and a scoreboard compares each result transaction in order.
// ----------------------------------------------------------------------------
module tb_top
    import gap_pkg::*;
();

    typedef struct packed {
        logic [VIDX_W-1:0] vertex_index;
        logic              is_cut_vertex;
        logic              last_vertex;
    } vertex_result_t;

    class cut_vertex_scoreboard;
        logic [63:0]    adj_rows [64];
        logic [6:0]     vcount;
        vertex_result_t pending_results [$];
        int             mismatches;

        function new();
            foreach (adj_rows[i]) adj_rows[i] = '0;
            vcount = 7'd64;
            mismatches = 0;
        endfunction

        function int active_count();
            return (vcount > 7'd64) ? 64 : int'(vcount);
        endfunction

        function void find_cut_vertices(int n);
            logic [6:0]  disc [64];
            logic [6:0]  low [64];
            logic [6:0]  par [64];
            logic [6:0]  scan [64];
            int          stk [$];
            logic [63:0] cut;
            logic [6:0]  timer;
            int          kids, u, v, p;
            cut = '0;
            timer = '0;
            foreach (disc[i])
            begin
                disc[i] = NO_PARENT;
                par[i] = NO_PARENT;
            end
            for (int r = 0; r < n; r++)
            begin
                if (disc[r] != NO_PARENT) continue;
                kids = 0;
                disc[r] = timer; low[r] = timer; timer++; scan[r] = '0;
                stk = {};
                stk.insert(stk.size(), r);
                while (stk.size() > 0)
                begin
                    u = stk[$];
                    v = int'(scan[u]);
                    while (v < n && !adj_rows[u][v]) v++;
                    if (v < n)
                    begin
                        scan[u] = 7'(v + 1);
                        if (disc[v] == NO_PARENT)
                        begin
                            if (u == r) kids++;
                            disc[v] = timer; low[v] = timer; timer++;
                            par[v] = 7'(u); scan[v] = '0;
                            stk.insert(stk.size(), v);
                        end
                        else if (v != par[u] && disc[v] < low[u])
                            low[u] = disc[v];
                    end
                    else
                    begin
                        void'(stk.pop_back());
                        if (stk.size() > 0)
                        begin
                            p = stk[$];
                            if (low[u] < low[p]) low[p] = low[u];
                            if (par[p] != NO_PARENT && low[u] >= disc[p]) cut[p] = 1'b1;
                        end
                    end
                end
                if (kids > 1) cut[r] = 1'b1;
            end
            for (int i = 0; i < n; i++)
                pending_results.insert(pending_results.size(),
                    vertex_result_t'({6'(i), cut[i], i == n - 1}));
        endfunction

        function void note_edge(logic [5:0] a, logic [5:0] b, logic last);
            int n;
            n = active_count();
            if (a < n && b < n && a != b)
            begin
                adj_rows[a][b] = 1'b1;
                adj_rows[b][a] = 1'b1;
            end
            if (last)
            begin
                find_cut_vertices(n);
                foreach (adj_rows[i]) adj_rows[i] = '0;
            end
        endfunction

        function void check_result(vertex_result_t got);
            vertex_result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              edge_valid = 1'b0;
    logic              edge_ready;
    logic [VIDX_W-1:0] edge_a = '0, edge_b = '0;
    logic              last_edge = 1'b0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic [VIDX_W-1:0] vertex_index;
    logic              is_cut_vertex, last_vertex;

    localparam logic [1:0] ADDR_VERTEX_COUNT = 2'd0;
    localparam int         WATCHDOG_LIMIT = 50000;

    cut_vertex_scoreboard sb = new();
    bit  calm_phase = 0;
    bit  hold_off = 0;
    int  idle_cycles = 0;

    graph_articulation_point_finder dut (.*);

    always #5 clk = ~clk;

    task automatic write_vertex_count(int value);
        edge_valid <= 1'b0;
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_VERTEX_COUNT; pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.vcount = 7'(value);
    endtask

    task automatic send_edge(int a, int b, bit last);
        if (!calm_phase && $urandom_range(0, 3) == 0)
        begin
            edge_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        edge_valid <= 1'b1; edge_a <= 6'(a); edge_b <= 6'(b); last_edge <= last;
        do @(posedge clk); while (!edge_ready);
        sb.note_edge(6'(a), 6'(b), last);
    endtask

    task automatic drain_and_settle();
        edge_valid <= 1'b0;
        while (sb.pending_results.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // random graph whose edges mostly fall inside the active count
    task automatic send_graph(int edges);
        int n;
        n = sb.active_count();
        if (n == 0) n = 1;
        for (int e = 0; e < edges; e++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_edge($urandom_range(0, 63), $urandom_range(0, 63), e == edges - 1);
            else
                send_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1), e == edges - 1);
        end
    endtask

    always @(posedge clk)
    begin
        if (result_valid && result_ready)
            sb.check_result({vertex_index, is_cut_vertex, last_vertex});
    end

    // receiver readiness, with bursts of stall and one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                result_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            else if (!calm_phase && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((edge_valid && edge_ready) || (result_valid && result_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** graph_articulation_point_finder: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // path 63-0-1-2-3 at reset count: 0, 1 and 2 cut, plus self loop and dup
        send_edge(0, 1, 0); send_edge(1, 2, 0); send_edge(2, 1, 0);
        send_edge(3, 3, 0); send_edge(2, 3, 0); send_edge(63, 0, 1);
        drain_and_settle();
        write_vertex_count(1);
        send_edge(0, 0, 1);
        drain_and_settle();
        write_vertex_count(0);
        send_edge(0, 1, 1);
        drain_and_settle();
        write_vertex_count(127);
        send_edge(0, 63, 0); send_edge(63, 62, 0); send_edge(62, 0, 0);
        send_edge(62, 5, 0); send_edge(42, 21, 0); send_edge(21, 42, 1);
        drain_and_settle();
        // star around vertex 0, count changed mid graph
        write_vertex_count(5);
        send_edge(0, 1, 0); send_edge(0, 2, 0); send_edge(0, 6, 0);
        write_vertex_count(8);
        send_edge(0, 6, 0); send_edge(0, 7, 1);
        drain_and_settle();

        // long receiver stall while a graph is closed and the next one queues
        write_vertex_count(6);
        hold_off = 1;
        send_graph(8);
        send_graph(6);
        drain_and_settle();

        for (int g = 0; g < 40; g++)
        begin
            if (g >= 34) calm_phase = 1;
            case ($urandom_range(0, 9))
                0: write_vertex_count(64);
                1: write_vertex_count($urandom_range(65, 127));
                2: write_vertex_count($urandom_range(1, 2));
                default: write_vertex_count($urandom_range(3, 16));
            endcase
            send_graph($urandom_range(1, 20));
            drain_and_settle();
        end

        drain_and_settle();
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("** graph_articulation_point_finder: PASSED **");
        else
            $display("** graph_articulation_point_finder: FAILED **");
        $finish;
    end

endmodule
